@@ rtl/core/mtb_pkg.sv @@
// Shared types and constants for the multi timer bank.
`default_nettype none
package mtb_pkg;
  // bank size and time width
  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 48;

  typedef enum logic [2:0] {
    CMD_SETUP = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_PROC  = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_ALREADY     = 2'd1;
  localparam logic [1:0] ST_NOT_STARTED = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_DIV,
    S_WB,
    S_SCAN_RD,
    S_SCAN_EVAL,
    S_SCAN_DIV,
    S_SCAN_WB,
    S_SCAN_EMIT,
    S_SUM,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

@@ rtl/core/mtb_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module mtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write into array, read registered (a same-address write returns the old data)
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ rtl/core/mtb_catchup.sv @@
// Iterative catch-up unit: step = sat(floor(diff/p)*p + p), one quotient bit per cycle.
`default_nettype none
module mtb_catchup #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] diff,
  input  wire logic [TIME_BITS-1:0] per,
  input  wire logic [TIME_BITS-1:0] dl,
  output logic                      done,
  output logic [TIME_BITS-1:0]      new_dl
);
  localparam int CW = $clog2(TIME_BITS + 1);
  logic [TIME_BITS-1:0] rem_r, rem_nxt, num_r, num_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [TIME_BITS:0]   trial;
  // restoring division step; remainder r = diff - q*p so q*p = diff - r
  logic [TIME_BITS:0]   step_w, sum_w;
  logic [TIME_BITS-1:0] step_s;

  always_comb begin
    trial    = {rem_r, num_r[TIME_BITS-1]};
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      num_nxt  = diff;
      cnt_nxt  = CW'(TIME_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[TIME_BITS-2:0], 1'b0};
      if (trial >= {1'b0, per}) begin
        rem_nxt = TIME_BITS'(trial - {1'b0, per});
      end else begin
        rem_nxt = trial[TIME_BITS-1:0];
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  // finish: q*p = diff - rem, never exceeds the time range; add p, saturate
  always_comb begin
    step_w = {1'b0, diff - rem_r} + {1'b0, per};
    step_s = step_w[TIME_BITS] ? '1 : step_w[TIME_BITS-1:0];
    sum_w  = {1'b0, dl} + {1'b0, step_s};
    new_dl = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
  end

  assign done = !busy_r && !start;
endmodule
`default_nettype wire

@@ rtl/core/multi_timer_bank.sv @@
// Top level of the multi timer bank: command sequencer over slot memories.
// Usage:
//  One request on in_* carries a command (set up, start, stop, query,
//  process). Each request produces one or more results on out_*; the final
//  one has out_last set. Process yields one fired result per expired started
//  slot, newest started first, then a summary with the fire count and the
//  distance to the nearest remaining deadline.
//  Requests are handled one at a time; in_ready is high only when idle.
//  Steps: set up, stop and query pass through read and write-back. Start
//  of a stopped slot adds a modify and a divide step, in which an overdue
//  periodic slot is caught up on the serial divider. Process reads and
//  evaluates each started slot, catches up a periodic expiry on the divider,
//  emits a result per expiry, then scans all slots for the summary. A new
//  request is taken the cycle after the last result is loaded.
//  Slot deadline and period live in one memory with a registered read;
//  started, armed and rank bits are flip-flops that reset clears. Unarmed
//  slots are never evaluated, so the memory needs no clearing.
//  When the receiver stalls the result stays on out_* and the sequencer
//  waits before loading the next one.
`default_nettype none
module multi_timer_bank (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [3:0]  in_slot,
  input  wire logic [47:0] in_delay,
  input  wire logic [47:0] in_period,
  input  wire logic [47:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [3:0]       out_fired_slot,
  output logic [1:0]       out_status,
  output logic             out_is_started,
  output logic [4:0]       out_fired_count,
  output logic             out_has_deadline,
  output logic [47:0]      out_next_delta,
  output logic             out_last
);
  localparam int NUM_TIMERS = mtb_pkg::NUM_TIMERS;
  localparam int TIME_BITS  = mtb_pkg::TIME_BITS;
  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int MW = 2 * TIME_BITS;

  mtb_pkg::state_t st_r, st_nxt;
  logic [2:0]           cmd_r;
  logic [3:0]           slot_r;
  logic [TIME_BITS-1:0] dly_r, per_r, now_r;
  logic                 ok_r;
  logic [SW-1:0]        sidx;
  logic [NUM_TIMERS-1:0] started_r, armed_r;
  logic [SW-1:0]        rank_r [NUM_TIMERS];
  logic [SW-1:0]        byrank_r [NUM_TIMERS];
  logic [CW-1:0]        nstart_r, ridx_r;
  logic [SW-1:0]        cur_r;
  logic [CW-1:0]        nfire_r;
  logic                 have_r;
  logic [TIME_BITS-1:0] best_r;
  logic [CW-1:0]        sumi_r;

  // memory: {period, deadline}
  logic                 m_we;
  logic [SW-1:0]        m_addr;
  logic [MW-1:0]        m_wd, m_rd;
  logic [TIME_BITS-1:0] m_dl, m_per;
  assign m_dl  = m_rd[TIME_BITS-1:0];
  assign m_per = m_rd[MW-1:TIME_BITS];

  // divider
  logic                 cu_go, cu_done;
  logic [TIME_BITS-1:0] cu_new;
  logic [TIME_BITS-1:0] m_dl_hold, m_per_hold;
  logic                 div_first_r;
  logic [SW-1:0]        m_addr_cur;

  // output register
  logic                 ov_r;
  logic                 o_kind_r, o_ist_r, o_hd_r, o_last_r;
  logic [3:0]           o_fs_r;
  logic [1:0]           o_st_r;
  logic [4:0]           o_cnt_r;
  logic [47:0]          o_nd_r;

  logic [TIME_BITS:0] sadd;
  logic [TIME_BITS-1:0] setup_dl;

  assign sidx     = SW'(slot_r);
  assign sadd     = {1'b0, now_r} + {1'b0, dly_r};
  assign setup_dl = sadd[TIME_BITS] ? '1 : sadd[TIME_BITS-1:0];
  assign in_ready = (st_r == mtb_pkg::S_IDLE);
  assign m_addr_cur = (cmd_r == mtb_pkg::CMD_PROC) ? cur_r : sidx;

  mtb_ram #(.WIDTH(MW), .DEPTH(NUM_TIMERS)) u_ram (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
  );

  mtb_catchup #(.TIME_BITS(TIME_BITS)) u_cu (
    .clk(clk), .rst_n(rst_n), .start(cu_go),
    .diff(now_r - m_dl_hold), .per(m_per_hold), .dl(m_dl_hold),
    .done(cu_done), .new_dl(cu_new)
  );

  // state machine
  logic                 emit_go;
  logic                 need_cu;
  always_comb begin
    st_nxt  = st_r;
    m_we    = 1'b0;
    m_addr  = sidx;
    m_wd    = {m_per_hold, m_dl_hold};
    cu_go   = 1'b0;
    emit_go = 1'b0;
    need_cu = (m_per_hold != '0) && armed_r[m_addr_cur] && (m_dl_hold <= now_r);
    case (st_r)
      mtb_pkg::S_IDLE: if (in_valid) st_nxt = mtb_pkg::S_RD;
      mtb_pkg::S_RD: begin
        if (cmd_r == mtb_pkg::CMD_PROC) st_nxt = (nstart_r == '0) ? mtb_pkg::S_SUM
                                                                    : mtb_pkg::S_SCAN_RD;
        else if (cmd_r == mtb_pkg::CMD_START && ok_r && !started_r[sidx])
          st_nxt = mtb_pkg::S_MOD;
        else st_nxt = mtb_pkg::S_WB;
      end
      mtb_pkg::S_MOD: st_nxt = mtb_pkg::S_DIV;
      mtb_pkg::S_DIV: begin
        if (!need_cu) st_nxt = mtb_pkg::S_WB;
        else if (div_first_r) cu_go = 1'b1;
        else if (cu_done) begin
          m_we = 1'b1;
          m_wd = {m_per_hold, cu_new};
          st_nxt = mtb_pkg::S_WB;
        end
      end
      // update and emit the completion once the output register is free
      mtb_pkg::S_WB: if (!ov_r) begin
        if (cmd_r == mtb_pkg::CMD_SETUP && ok_r) begin
          m_we = 1'b1;
          m_wd = {per_r, setup_dl};
        end
        emit_go = 1'b1;
        st_nxt  = mtb_pkg::S_IDLE;
      end
      mtb_pkg::S_SCAN_RD: begin
        m_addr = byrank_r[ridx_r[SW-1:0]];
        st_nxt = mtb_pkg::S_SCAN_EVAL;
      end
      mtb_pkg::S_SCAN_EVAL: begin
        m_addr = cur_r;
        st_nxt = mtb_pkg::S_SCAN_DIV;
      end
      mtb_pkg::S_SCAN_DIV: begin
        m_addr = cur_r;
        if (!(armed_r[cur_r] && m_dl_hold <= now_r)) st_nxt = mtb_pkg::S_SCAN_WB;
        else if (m_per_hold == '0) st_nxt = mtb_pkg::S_SCAN_EMIT;
        else if (div_first_r) cu_go = 1'b1;
        else if (cu_done) begin
          m_we = 1'b1;
          m_wd = {m_per_hold, cu_new};
          st_nxt = mtb_pkg::S_SCAN_EMIT;
        end
      end
      mtb_pkg::S_SCAN_EMIT: begin
        m_addr = cur_r;
        if (!ov_r) begin
          emit_go = 1'b1;
          st_nxt  = mtb_pkg::S_SCAN_WB;
        end
      end
      mtb_pkg::S_SCAN_WB: begin
        st_nxt = (ridx_r + 1'b1 >= nstart_r) ? mtb_pkg::S_SUM : mtb_pkg::S_SCAN_RD;
      end
      mtb_pkg::S_SUM: begin
        m_addr = SW'(sumi_r);
        if (sumi_r == CW'(NUM_TIMERS) + 1'b1) st_nxt = mtb_pkg::S_OUT;
      end
      mtb_pkg::S_OUT: if (!ov_r) begin
        emit_go = 1'b1;
        st_nxt  = mtb_pkg::S_IDLE;
      end
      default: st_nxt = mtb_pkg::S_IDLE;
    endcase
  end

  // sequencer registers
  logic [SW-1:0] sum_prev;
  logic [TIME_BITS-1:0] dlt;
  assign dlt = m_dl - now_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= mtb_pkg::S_IDLE;
      started_r <= '0;
      armed_r   <= '0;
      nstart_r  <= '0;
      ov_r      <= 1'b0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
        rank_r[k]   <= '0;
        byrank_r[k] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        mtb_pkg::S_IDLE: if (in_valid) begin
          cmd_r  <= in_cmd;
          slot_r <= in_slot;
          ok_r   <= {28'd0, in_slot} < NUM_TIMERS;
          dly_r  <= TIME_BITS'(in_delay);
          per_r  <= TIME_BITS'(in_period);
          now_r  <= TIME_BITS'(in_now_time);
          ridx_r <= '0;
          nfire_r <= '0;
          have_r <= 1'b0;
          best_r <= '1;
          sumi_r <= '0;
        end
        mtb_pkg::S_MOD: begin
          m_dl_hold   <= m_dl;
          m_per_hold  <= m_per;
          div_first_r <= 1'b1;
        end
        mtb_pkg::S_DIV, mtb_pkg::S_SCAN_DIV: div_first_r <= 1'b0;
        mtb_pkg::S_WB: if (!ov_r) begin
          if (cmd_r == mtb_pkg::CMD_SETUP && ok_r) armed_r[sidx] <= 1'b1;
          if (cmd_r == mtb_pkg::CMD_START && ok_r && !started_r[sidx]) begin
            for (int k = 0; k < NUM_TIMERS; k++)
              if (started_r[k]) rank_r[k] <= rank_r[k] + 1'b1;
            for (int k = 1; k < NUM_TIMERS; k++)
              byrank_r[k] <= byrank_r[k-1];
            byrank_r[0]     <= sidx;
            rank_r[sidx]    <= '0;
            started_r[sidx] <= 1'b1;
            nstart_r        <= nstart_r + 1'b1;
          end
          if (cmd_r == mtb_pkg::CMD_STOP && ok_r && started_r[sidx]) begin
            for (int k = 0; k < NUM_TIMERS; k++)
              if (started_r[k] && rank_r[k] > rank_r[sidx]) rank_r[k] <= rank_r[k] - 1'b1;
            for (int k = 0; k < NUM_TIMERS - 1; k++)
              if (SW'(k) >= rank_r[sidx]) byrank_r[k] <= byrank_r[k+1];
            rank_r[sidx]    <= '0;
            started_r[sidx] <= 1'b0;
            nstart_r        <= nstart_r - 1'b1;
          end
          o_kind_r <= 1'b1;
          o_fs_r   <= '0;
          o_cnt_r  <= '0;
          o_hd_r   <= 1'b0;
          o_nd_r   <= '0;
          o_last_r <= 1'b1;
          o_ist_r  <= (cmd_r == mtb_pkg::CMD_QUERY) && ok_r && started_r[sidx];
          o_st_r   <= (cmd_r == mtb_pkg::CMD_START && ok_r && started_r[sidx])
                      ? mtb_pkg::ST_ALREADY
                      : (cmd_r == mtb_pkg::CMD_STOP && !(ok_r && started_r[sidx]))
                      ? mtb_pkg::ST_NOT_STARTED : mtb_pkg::ST_OK;
        end
        mtb_pkg::S_SCAN_RD: cur_r <= byrank_r[ridx_r[SW-1:0]];
        mtb_pkg::S_SCAN_EVAL: begin
          m_dl_hold   <= m_dl;
          m_per_hold  <= m_per;
          div_first_r <= 1'b1;
        end
        mtb_pkg::S_SCAN_EMIT: if (!ov_r) begin
          if (m_per_hold == '0) armed_r[cur_r] <= 1'b0;
          nfire_r <= nfire_r + 1'b1;
          o_kind_r <= 1'b0;
          o_fs_r   <= 4'(cur_r);
          o_st_r   <= mtb_pkg::ST_OK;
          o_ist_r  <= 1'b0;
          o_cnt_r  <= '0;
          o_hd_r   <= 1'b0;
          o_nd_r   <= '0;
          o_last_r <= 1'b0;
        end
        mtb_pkg::S_SCAN_WB: ridx_r <= ridx_r + 1'b1;
        mtb_pkg::S_SUM: begin
          sumi_r   <= sumi_r + 1'b1;
          sum_prev <= SW'(sumi_r);
          if (sumi_r != '0 && started_r[sum_prev] && armed_r[sum_prev] && m_dl > now_r) begin
            have_r <= 1'b1;
            if (dlt < best_r) best_r <= dlt;
          end
        end
        // summary loads only once the last fired result has left
        mtb_pkg::S_OUT: if (!ov_r) begin
          o_kind_r <= 1'b1;
          o_fs_r   <= '0;
          o_st_r   <= mtb_pkg::ST_OK;
          o_ist_r  <= 1'b0;
          o_cnt_r  <= 5'(nfire_r);
          o_hd_r   <= have_r;
          o_nd_r   <= best_r;
          o_last_r <= 1'b1;
        end
        default: ;
      endcase
      if (emit_go) ov_r <= 1'b1;
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = o_kind_r;
  assign out_fired_slot   = o_fs_r;
  assign out_status       = o_st_r;
  assign out_is_started   = o_ist_r;
  assign out_fired_count  = o_cnt_r;
  assign out_has_deadline = o_hd_r;
  assign out_next_delta   = o_nd_r;
  assign out_last         = o_last_r;

  // checks
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    nstart_r == CW'($countones(started_r))) else $error("start count mismatch");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(st_r == mtb_pkg::S_SCAN_EMIT)) else $error("ready in scan");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fired_slot))
    else $error("output dropped");
endmodule
`default_nettype wire

@@ test/tb_multi_timer_bank.sv @@
// Self-checking testbench for the multi timer bank command sequencer.
`default_nettype none
module tb_multi_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 16;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [3:0]  fired_slot;
    logic [1:0]  status;
    logic        is_started;
    logic [4:0]  fired_count;
    logic        has_deadline;
    logic [47:0] next_delta;
    logic        last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [3:0] in_slot = '0;
  logic [47:0] in_delay = '0, in_period = '0, in_now_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind, out_is_started, out_has_deadline, out_last;
  logic [3:0] out_fired_slot;
  logic [1:0] out_status;
  logic [4:0] out_fired_count;
  logic [47:0] out_next_delta;

  multi_timer_bank DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timer bank shadow state
  logic [47:0] sh_deadline [NT];
  logic [47:0] sh_period [NT];
  bit sh_armed [NT];
  bit sh_started [NT];
  int unsigned sh_rank [NT];

  timer_result_t pending_results[$];
  int errors = 0;
  int hold_off = 0;
  bit rx_busy_mode = 1'b0;
  logic [47:0] cur_time = '0;

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic void advance_deadline(int s, logic [47:0] now);
    logic [47:0] diff, p;
    logic [95:0] m;
    p = sh_period[s];
    if (p == 0 || !sh_armed[s] || sh_deadline[s] > now) return;
    diff = now - sh_deadline[s];
    m = (diff / p) * p;
    sh_deadline[s] = add_sat(sh_deadline[s], add_sat(m[47:0], p));
  endfunction

  function automatic timer_result_t done_result(logic [1:0] st, logic isst);
    timer_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.is_started = isst;
    r.last = 1'b1;
    return r;
  endfunction

  // expected results of one request, shadow state updated
  function automatic void predict_timers(logic [2:0] cmd, logic [3:0] s,
      logic [47:0] dly, logic [47:0] per, logic [47:0] now);
    timer_result_t r;
    logic [47:0] best, d;
    bit have;
    int n;
    logic [1:0] st;
    have = 0;
    n = 0;
    best = TMAX;
    case (cmd)
      mtb_pkg::CMD_PROC: begin
        for (int rk = 0; rk < NT; rk++)
          for (int i = 0; i < NT; i++) begin
            if (!sh_started[i] || sh_rank[i] != rk) continue;
            if (sh_armed[i] && sh_deadline[i] <= now) begin
              if (sh_period[i] == 0) sh_armed[i] = 0;
              else advance_deadline(i, now);
              r = '0;
              r.fired_slot = i[3:0];
              pending_results.push_back(r);
              n++;
            end
            break;
          end
        for (int i = 0; i < NT; i++)
          if (sh_started[i] && sh_armed[i] && sh_deadline[i] > now) begin
            d = sh_deadline[i] - now;
            if (d < best) best = d;
            have = 1;
          end
        r = done_result(mtb_pkg::ST_OK, 1'b0);
        r.fired_count = n[4:0];
        r.has_deadline = have;
        r.next_delta = best;
        pending_results.push_back(r);
      end
      mtb_pkg::CMD_SETUP: begin
        sh_deadline[s] = add_sat(now, dly);
        sh_period[s] = per;
        sh_armed[s] = 1;
        pending_results.push_back(done_result(mtb_pkg::ST_OK, 1'b0));
      end
      mtb_pkg::CMD_START: begin
        st = mtb_pkg::ST_OK;
        if (sh_started[s]) st = mtb_pkg::ST_ALREADY;
        else begin
          advance_deadline(s, now);
          for (int i = 0; i < NT; i++) if (sh_started[i]) sh_rank[i]++;
          sh_started[s] = 1;
          sh_rank[s] = 0;
        end
        pending_results.push_back(done_result(st, 1'b0));
      end
      mtb_pkg::CMD_STOP: begin
        st = mtb_pkg::ST_NOT_STARTED;
        if (sh_started[s]) begin
          for (int i = 0; i < NT; i++)
            if (sh_started[i] && sh_rank[i] > sh_rank[s]) sh_rank[i]--;
          sh_started[s] = 0;
          sh_rank[s] = 0;
          st = mtb_pkg::ST_OK;
        end
        pending_results.push_back(done_result(st, 1'b0));
      end
      mtb_pkg::CMD_QUERY:
        pending_results.push_back(done_result(mtb_pkg::ST_OK, sh_started[s]));
      default: pending_results.push_back(done_result(mtb_pkg::ST_OK, 1'b0));
    endcase
  endfunction

  // send one request, holding it until accepted
  task automatic send_request(logic [2:0] cmd, logic [3:0] s, logic [47:0] dly,
      logic [47:0] per, logic [47:0] now);
    in_cmd <= cmd;
    in_slot <= s;
    in_delay <= dly;
    in_period <= per;
    in_now_time <= now;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timers(cmd, s, dly, per, now);
    @(negedge clk);
    // random gap between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // receiver stall pattern, with optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (rx_busy_mode)
      out_ready <= ($urandom_range(0, 3) != 0);
    else
      out_ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    timer_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_fired_slot, out_status, out_is_started, out_fired_count,
              out_has_deadline, out_next_delta, out_last};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  function automatic logic [47:0] rand_time();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    send_request(mtb_pkg::CMD_QUERY, 4'd0, '0, '0, '0);
    send_request(mtb_pkg::CMD_STOP, 4'd15, '0, '0, '0);
    send_request(mtb_pkg::CMD_PROC, 4'd0, '0, '0, '0);
    send_request(mtb_pkg::CMD_SETUP, 4'd0, 48'd10, 48'd0, 48'd100);
    send_request(mtb_pkg::CMD_SETUP, 4'd1, 48'd5, 48'd7, 48'd100);
    send_request(mtb_pkg::CMD_SETUP, 4'd15, TMAX, TMAX, TMAX);
    send_request(mtb_pkg::CMD_START, 4'd0, '0, '0, 48'd100);
    send_request(mtb_pkg::CMD_START, 4'd0, '0, '0, 48'd100);
    send_request(mtb_pkg::CMD_START, 4'd1, '0, '0, 48'd200);
    send_request(mtb_pkg::CMD_START, 4'd15, '0, '0, TMAX);
    send_request(mtb_pkg::CMD_QUERY, 4'd1, '0, '0, '0);
    send_request(mtb_pkg::CMD_PROC, 4'd0, '0, '0, 48'd300);
    send_request(mtb_pkg::CMD_PROC, 4'd0, '0, '0, TMAX);
    send_request(mtb_pkg::CMD_SETUP, 4'd2, 48'd0, 48'd1, TMAX - 48'd3);
    send_request(mtb_pkg::CMD_START, 4'd2, '0, '0, TMAX);
    send_request(mtb_pkg::CMD_PROC, 4'd0, '0, '0, TMAX);
    send_request(mtb_pkg::CMD_STOP, 4'd1, '0, '0, '0);
    send_request(mtb_pkg::CMD_STOP, 4'd1, '0, '0, '0);
    send_request(3'd7, 4'd3, '1, '1, '1);
    send_request(3'd5, 4'd3, '0, '0, '0);
    send_request(mtb_pkg::CMD_PROC, 4'd0, '0, '0, 48'd0);
  endtask

  // mostly realistic timer traffic around a slowly advancing clock
  task automatic test_random_traffic(int count);
    logic [2:0] cmd;
    logic [47:0] dly, per;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      cur_time = cur_time + 48'($urandom_range(0, 40));
      dly = 48'($urandom_range(0, 80));
      per = ($urandom_range(0, 2) == 0) ? 48'd0 : 48'($urandom_range(1, 30));
      if (pick < 5) begin
        dly = rand_time();
        per = rand_time();
      end
      if (pick < 25) cmd = mtb_pkg::CMD_SETUP;
      else if (pick < 45) cmd = mtb_pkg::CMD_START;
      else if (pick < 55) cmd = mtb_pkg::CMD_STOP;
      else if (pick < 65) cmd = mtb_pkg::CMD_QUERY;
      else if (pick < 97) cmd = mtb_pkg::CMD_PROC;
      else cmd = 3'($urandom_range(5, 7));
      send_request(cmd, 4'($urandom_range(0, 15)), dly, per,
                   (pick == 3) ? rand_time() : cur_time);
    end
  endtask

  task automatic test_output_backpressure();
    rx_busy_mode = 1'b1;
    hold_off = 300;
    test_random_traffic(20);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    pause_sender();
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NT; i++) begin
      sh_deadline[i] = '0;
      sh_period[i] = '0;
      sh_armed[i] = 0;
      sh_started[i] = 0;
      sh_rank[i] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(100);
    test_output_backpressure();
    rx_busy_mode = 1'b0;
    test_random_traffic(80);
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/core/mtb_pkg.sv
rtl/core/mtb_ram.sv
rtl/core/mtb_catchup.sv
rtl/core/multi_timer_bank.sv
test/tb_multi_timer_bank.sv
